>>> hdl/owsm_pkg.sv
// ----------------------------------------------------------------------------
// owsm_pkg
// Shared constants and types of the omni wheel speed mixer.
// ----------------------------------------------------------------------------
package owsm_pkg;

    localparam int NUM_WHEELS = 4;
    localparam int DIV_STAGES = 15;

    localparam logic [2:0] REG_LIMIT_VX        = 3'd0;
    localparam logic [2:0] REG_LIMIT_VY        = 3'd1;
    localparam logic [2:0] REG_LIMIT_VW        = 3'd2;
    localparam logic [2:0] REG_ROT_GAIN        = 3'd3;
    localparam logic [2:0] REG_RPM_GAIN        = 3'd4;
    localparam logic [2:0] REG_LIMIT_WHEEL_RPM = 3'd5;

    typedef struct packed {
        logic [15:0]        rem;
        logic [14:0]        lo;
        logic [14:0]        quo;
        logic signed [15:0] w;
    } lane_t;

    typedef struct packed {
        logic                        scale;
        logic [15:0]                 dvs;
        lane_t [NUM_WHEELS-1:0]      lane;
    } div_t;

endpackage

>>> hdl/omni_wheel_speed_mixer_top.sv
// ----------------------------------------------------------------------------
// omni_wheel_speed_mixer_top
// X-omni inverse kinematics with proportional desaturation of wheel speeds.
// ----------------------------------------------------------------------------
// One command word in, one word of four wheel speeds out. The datapath is a
// 23-stage pipeline (clamp, mix, sum, magnitude, gain multiply, saturate,
// peak search, 15 stages of a one-bit-per-stage divider, output register),
// so a new word is taken every cycle while no output stall holds it. Each
// stage holds its word while the next one is full, so a stall on the output
// only blocks input once every stage is occupied.
// Configuration writes are taken at any time and must only be issued while
// no word is in flight.
module omni_wheel_speed_mixer_top
    import owsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // cmd_vx, cmd_vy, cmd_vw
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // wheel_left, wheel_front, wheel_right, wheel_back
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [14:0] limit_vx_reg, limit_vy_reg, limit_vw_reg, limit_wheel_rpm_reg;
    logic [15:0] rot_gain_reg, rpm_gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_vx_reg        <= 15'd3000;
            limit_vy_reg        <= 15'd3000;
            limit_vw_reg        <= 15'd300;
            rot_gain_reg        <= 16'd0;
            rpm_gain_reg        <= 16'd0;
            limit_wheel_rpm_reg <= 15'd8000;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_LIMIT_VX:        limit_vx_reg        <= cfg_data[14:0];
                REG_LIMIT_VY:        limit_vy_reg        <= cfg_data[14:0];
                REG_LIMIT_VW:        limit_vw_reg        <= cfg_data[14:0];
                REG_ROT_GAIN:        rot_gain_reg        <= cfg_data;
                REG_RPM_GAIN:        rpm_gain_reg        <= cfg_data;
                REG_LIMIT_WHEEL_RPM: limit_wheel_rpm_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    function automatic logic signed [15:0] clamp_sym(input logic signed [15:0] v,
                                                     input logic [14:0] lim);
        logic signed [16:0] v17;
        logic signed [16:0] l17;
        logic signed [16:0] r17;
        v17 = 17'(v);
        l17 = $signed({2'b00, lim});
        if (v17 > l17) begin
            r17 = l17;
        end else if (v17 < -l17) begin
            r17 = -l17;
        end else begin
            r17 = v17;
        end
        return r17[15:0];
    endfunction

    // ready chain
    logic rdy_out;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
    logic rdy_d [DIV_STAGES+1];

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic dv_reg [DIV_STAGES];
    logic m_tvalid_reg;

    assign rdy_out = !m_tvalid_reg || m_tready;
    assign rdy_d[DIV_STAGES] = rdy_out;
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_rdy
        assign rdy_d[k] = !dv_reg[k] || rdy_d[k+1];
    end
    assign rdy7 = !v7_reg || rdy_d[0];
    assign rdy6 = !v6_reg || rdy7;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // stage 1: clamp
    logic signed [15:0] vx1_reg, vy1_reg, vw1_reg;
    logic signed [15:0] vx1_next, vy1_next, vw1_next;

    assign vx1_next = clamp_sym(s_tdata[15:0], limit_vx_reg);
    assign vy1_next = clamp_sym(s_tdata[31:16], limit_vy_reg);
    assign vw1_next = clamp_sym(s_tdata[47:32], limit_vw_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            vx1_reg <= vx1_next;
            vy1_reg <= vy1_next;
            vw1_reg <= vw1_next;
        end
    end

    // stage 2: wheel mixing and rotation product
    logic signed [16:0] lin2_reg  [NUM_WHEELS];
    logic signed [16:0] lin2_next [NUM_WHEELS];
    logic signed [31:0] rot2_reg, rot2_next;
    logic signed [16:0] vx17, vy17, vw17, gain17;
    logic signed [33:0] rot_full;

    assign vx17      = 17'(vx1_reg);
    assign vy17      = 17'(vy1_reg);
    assign vw17      = 17'(vw1_reg);
    assign gain17    = $signed({1'b0, rot_gain_reg});
    assign rot_full  = vw17 * gain17;
    assign rot2_next = rot_full[31:0];
    assign lin2_next[0] =  vx17 + vy17;
    assign lin2_next[1] =  vx17 - vy17;
    assign lin2_next[2] = -vx17 - vy17;
    assign lin2_next[3] = -vx17 + vy17;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            lin2_reg <= lin2_next;
            rot2_reg <= rot2_next;
        end
    end

    // stage 3: Q.8 wheel sum
    logic signed [32:0] s3_reg  [NUM_WHEELS];
    logic signed [32:0] s3_next [NUM_WHEELS];

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            s3_next[i] = $signed({{8{lin2_reg[i][16]}}, lin2_reg[i], 8'h00})
                       + 33'(rot2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            s3_reg <= s3_next;
        end
    end

    // stage 4: sign and magnitude
    logic        neg4_reg  [NUM_WHEELS];
    logic        neg4_next [NUM_WHEELS];
    logic [31:0] mag4_reg  [NUM_WHEELS];
    logic [31:0] mag4_next [NUM_WHEELS];
    logic [32:0] s_abs     [NUM_WHEELS];

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            neg4_next[i] = s3_reg[i][32];
            s_abs[i]     = neg4_next[i] ? 33'(-s3_reg[i]) : 33'(s3_reg[i]);
            mag4_next[i] = s_abs[i][31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (rdy4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            neg4_reg <= neg4_next;
            mag4_reg <= mag4_next;
        end
    end

    // stage 5: rpm gain, Q.24
    logic        neg5_reg  [NUM_WHEELS];
    logic [47:0] prod5_reg [NUM_WHEELS];
    logic [47:0] prod5_next [NUM_WHEELS];

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            prod5_next[i] = 48'(mag4_reg[i]) * 48'(rpm_gain_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (rdy5) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            neg5_reg  <= neg4_reg;
            prod5_reg <= prod5_next;
        end
    end

    // stage 6: truncate toward zero and saturate
    logic signed [15:0] w6_reg    [NUM_WHEELS];
    logic signed [15:0] w6_next   [NUM_WHEELS];
    logic [15:0]        mag6_reg  [NUM_WHEELS];
    logic [15:0]        mag6_next [NUM_WHEELS];
    logic [23:0]        qmag      [NUM_WHEELS];

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            qmag[i] = prod5_reg[i][47:24];
            if (neg5_reg[i]) begin
                mag6_next[i] = (qmag[i] > 24'd32768) ? 16'd32768 : qmag[i][15:0];
                w6_next[i]   = $signed(-mag6_next[i]);
            end else begin
                mag6_next[i] = (qmag[i] > 24'd32767) ? 16'd32767 : qmag[i][15:0];
                w6_next[i]   = $signed(mag6_next[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (rdy6) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy6) begin
            w6_reg   <= w6_next;
            mag6_reg <= mag6_next;
        end
    end

    // stage 7: peak magnitude, scale decision, dividends
    div_t        div_reg [DIV_STAGES+1];
    div_t        div0_next;
    logic [15:0] max01, max23, maxmag;
    logic [29:0] num [NUM_WHEELS];
    logic [30:0] num_full [NUM_WHEELS];

    assign max01  = (mag6_reg[0] > mag6_reg[1]) ? mag6_reg[0] : mag6_reg[1];
    assign max23  = (mag6_reg[2] > mag6_reg[3]) ? mag6_reg[2] : mag6_reg[3];
    assign maxmag = (max01 > max23) ? max01 : max23;

    always_comb begin
        div0_next.scale = maxmag > {1'b0, limit_wheel_rpm_reg};
        div0_next.dvs   = maxmag;
        for (int i = 0; i < NUM_WHEELS; i++) begin
            num_full[i] = 31'(mag6_reg[i]) * 31'(limit_wheel_rpm_reg);
            num[i]      = num_full[i][29:0];
            div0_next.lane[i].rem = {1'b0, num[i][29:15]};
            div0_next.lane[i].lo  = num[i][14:0];
            div0_next.lane[i].quo = '0;
            div0_next.lane[i].w   = w6_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (rdy7) begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy7) begin
            div_reg[0] <= div0_next;
        end
    end

    // divider: one quotient bit per stage
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        div_t        stg_next;
        logic [16:0] trial [NUM_WHEELS];
        logic [16:0] diff  [NUM_WHEELS];
        logic        ge    [NUM_WHEELS];

        always_comb begin
            stg_next = div_reg[k];
            for (int i = 0; i < NUM_WHEELS; i++) begin
                trial[i] = {div_reg[k].lane[i].rem, div_reg[k].lane[i].lo[14]};
                diff[i]  = trial[i] - {1'b0, div_reg[k].dvs};
                ge[i]    = trial[i] >= {1'b0, div_reg[k].dvs};
                stg_next.lane[i].rem = ge[i] ? diff[i][15:0] : trial[i][15:0];
                stg_next.lane[i].lo  = {div_reg[k].lane[i].lo[13:0], 1'b0};
                stg_next.lane[i].quo = {div_reg[k].lane[i].quo[13:0], ge[i]};
            end
        end

        if (k == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    dv_reg[k] <= 1'b0;
                end else if (rdy_d[k]) begin
                    dv_reg[k] <= v7_reg;
                end
            end
        end else begin : g_rest
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    dv_reg[k] <= 1'b0;
                end else if (rdy_d[k]) begin
                    dv_reg[k] <= dv_reg[k-1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy_d[k]) begin
                div_reg[k+1] <= stg_next;
            end
        end
    end

    // output register
    logic [63:0]        m_tdata_reg, m_tdata_next;
    logic signed [15:0] scaled [NUM_WHEELS];
    div_t               dfin;

    assign dfin = div_reg[DIV_STAGES];

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            if (!dfin.scale) begin
                scaled[i] = dfin.lane[i].w;
            end else if (dfin.lane[i].w[15]) begin
                scaled[i] = $signed(-{1'b0, dfin.lane[i].quo});
            end else begin
                scaled[i] = $signed({1'b0, dfin.lane[i].quo});
            end
        end
        m_tdata_next = {scaled[3], scaled[2], scaled[1], scaled[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (rdy_out) begin
            m_tvalid_reg <= dv_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_out) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_open_out_takes_input : assert property (@(posedge aclk) disable iff (!aresetn)
        rdy_out |-> s_tready)
        else $error("input blocked while output side can move");

    a_reset_clears_output : assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid_reg)
        else $error("output valid after reset");

    a_peak_stage_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        v7_reg && !rdy_d[0] |=> v7_reg && $stable(div_reg[0]))
        else $error("peak stage lost a word under stall");

endmodule

>>> sim/omni_wheel_speed_mixer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// omni_wheel_speed_mixer_top_test
// Self-checking testbench of the X-omni wheel speed mixer.
// ----------------------------------------------------------------------------
// Drives chassis velocity words through the stream input and predicts the four
// wheel speeds of each one in a fixed-point mixer of its own: clamp, mix,
// gain, saturate and proportional scaling against the wheel limit. Every
// output word is compared field by field with the oldest prediction. The run
// covers reset values, field extremes, zero limits, a zero wheel limit,
// register bits above each width, writes to unused indexes, random register
// settings with random words, random gaps on both sides, a long output stall
// that fills the pipeline and a sender pause until the pipeline is empty.
module omni_wheel_speed_mixer_top_test;
    import owsm_pkg::*;

    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam int QUIET_LIMIT  = 2000;
    localparam int FLUSH_CYCLES = 30;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 95;

    typedef struct packed {
        logic signed [15:0] vw;
        logic signed [15:0] vy;
        logic signed [15:0] vx;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] wheel_back;
        logic signed [15:0] wheel_right;
        logic signed [15:0] wheel_front;
        logic signed [15:0] wheel_left;
    } wheel_set_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int reg_limit_vx    = 3000;
    int reg_limit_vy    = 3000;
    int reg_limit_vw    = 300;
    int reg_rot_gain    = 0;
    int reg_rpm_gain    = 0;
    int reg_limit_wheel = 8000;

    wheel_set_t pending_wheels[$];
    int         mismatch_count = 0;
    int         quiet_cycles = 0;
    int         rx_wait = 0;
    logic       rx_hold_on = 1'b0;
    logic       rx_idle = 1'b0;
    bit         send_idle = 1'b0;

    string wheel_names[4] = '{"wheel_left", "wheel_front", "wheel_right", "wheel_back"};

    omni_wheel_speed_mixer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // cmd_vx, cmd_vy, cmd_vw
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // wheel_left, wheel_front, wheel_right, wheel_back
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic wheel_set_t mix_wheels(cmd_t c);
        longint vx, vy, vw, rot, s, p, q, peak, mag;
        longint lin[4];
        longint w[4];
        wheel_set_t r;
        vx = clamp_sym(c.vx, reg_limit_vx);
        vy = clamp_sym(c.vy, reg_limit_vy);
        vw = clamp_sym(c.vw, reg_limit_vw);
        rot = vw * reg_rot_gain;
        lin[0] = vx + vy;
        lin[1] = vx - vy;
        lin[2] = -vx - vy;
        lin[3] = -vx + vy;
        peak = 0;
        for (int i = 0; i < 4; i++) begin
            s = lin[i] * 256 + rot;
            p = s * reg_rpm_gain;
            q = (p < 0) ? -((-p) >>> 24) : (p >>> 24);
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            w[i] = q;
            mag = (q < 0) ? -q : q;
            if (mag > peak) peak = mag;
        end
        if (peak > reg_limit_wheel) begin
            for (int i = 0; i < 4; i++)
                w[i] = (w[i] * reg_limit_wheel) / peak;
        end
        r.wheel_left  = 16'(w[0]);
        r.wheel_front = 16'(w[1]);
        r.wheel_right = 16'(w[2]);
        r.wheel_back  = 16'(w[3]);
        return r;
    endfunction

    function automatic logic signed [15:0] rand_speed(int lim);
        int v;
        case ($urandom_range(0, 5))
            0, 1: v = int'($urandom_range(0, 65535)) - 32768;
            2, 3: v = int'($urandom_range(0, 2 * lim)) - lim;
            4: v = int'($urandom_range(0, 128)) - 64;
            default: begin
                case ($urandom_range(0, 3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = lim;
                    default: v = -lim;
                endcase
            end
        endcase
        return 16'(v);
    endfunction

    function automatic logic [15:0] rand_reg(int typical);
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, typical));
        endcase
    endfunction

    always @(posedge aclk) begin : wheel_sink
        logic [63:0] want;
        logic [15:0] got;
        int stall;
        if (m_tvalid && m_tready) begin
            if (pending_wheels.size() == 0) begin
                $error("unexpected wheel word %h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_wheels.pop_front();
                for (int i = 0; i < 4; i++) begin
                    got = m_tdata[16*i +: 16];
                    if (got !== want[16*i +: 16]) begin
                        $error("%s: expected %0d, got %0d", wheel_names[i],
                               $signed(want[16*i +: 16]), $signed(got));
                        mismatch_count++;
                    end
                end
            end
        end
        if (!aresetn || rx_hold_on) begin
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait  <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end else if (m_tvalid && m_tready) begin
            stall = rx_idle ? $urandom_range(0, 19) : 0;
            rx_wait  <= stall;
            m_tready <= (stall == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_cmd(logic signed [15:0] vx, logic signed [15:0] vy,
                            logic signed [15:0] vw);
        cmd_t c;
        int gap;
        c.vx = vx;
        c.vy = vy;
        c.vw = vw;
        gap = send_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        pending_wheels.push_back(mix_wheels(c));
    endtask

    // hold the last word's valid low and wait for every wheel word to come back
    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_wheels.size() != 0);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_LIMIT_VX:        reg_limit_vx    = int'(val[14:0]);
            REG_LIMIT_VY:        reg_limit_vy    = int'(val[14:0]);
            REG_LIMIT_VW:        reg_limit_vw    = int'(val[14:0]);
            REG_ROT_GAIN:        reg_rot_gain    = int'(val);
            REG_RPM_GAIN:        reg_rpm_gain    = int'(val);
            REG_LIMIT_WHEEL_RPM: reg_limit_wheel = int'(val[14:0]);
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] lvx, logic [15:0] lvy, logic [15:0] lvw,
                              logic [15:0] rot, logic [15:0] rpm, logic [15:0] lwheel);
        write_reg(REG_LIMIT_VX, lvx);
        write_reg(REG_LIMIT_VY, lvy);
        write_reg(REG_LIMIT_VW, lvw);
        write_reg(REG_ROT_GAIN, rot);
        write_reg(REG_RPM_GAIN, rpm);
        write_reg(REG_LIMIT_WHEEL_RPM, lwheel);
        cfg_valid <= 1'b0;
    endtask

    task automatic rx_hold(int cycles);
        rx_hold_on <= 1'b1;
        repeat (cycles) @(posedge aclk);
        rx_hold_on <= 1'b0;
    endtask

    task automatic test_reset_values;
        send_cmd(16'sd32767, -16'sd32768, 16'sd32767);
        send_cmd(-16'sd1, 16'sd1, -16'sd32768);
        drain();
    endtask

    task automatic test_field_extremes;
        set_config(16'd3000, 16'd3000, 16'd300, 16'h0180, 16'h3333, 16'd8000);
        send_cmd(16'sd0, 16'sd0, 16'sd0);
        send_cmd(16'sd32767, 16'sd0, 16'sd0);
        send_cmd(-16'sd32768, 16'sd0, 16'sd0);
        send_cmd(16'sd0, 16'sd32767, 16'sd0);
        send_cmd(16'sd0, -16'sd32768, 16'sd0);
        send_cmd(16'sd0, 16'sd0, 16'sd32767);
        send_cmd(16'sd0, 16'sd0, -16'sd32768);
        send_cmd(16'sd1000, -16'sd500, 16'sd90);
        drain();
    endtask

    task automatic test_zero_speed_limits;
        set_config(16'd0, 16'd0, 16'd32767, 16'hFFFF, 16'hFFFF, 16'd32767);
        send_cmd(16'sd12345, -16'sd32768, -16'sd32768);
        send_cmd(16'sd32767, 16'sd32767, 16'sd1);
        drain();
    endtask

    task automatic test_zero_wheel_limit;
        set_config(16'd32767, 16'd32767, 16'd32767, 16'hFFFF, 16'hFFFF, 16'd0);
        send_cmd(16'sd0, 16'sd0, 16'sd0);
        send_cmd(16'sd1, 16'sd0, 16'sd0);
        send_cmd(16'sd32767, -16'sd32768, 16'sd100);
        drain();
    endtask

    task automatic test_saturation;
        set_config(16'd32767, 16'd32767, 16'd32767, 16'hFFFF, 16'hFFFF, 16'd32767);
        send_cmd(16'sd32767, 16'sd32767, 16'sd32767);
        send_cmd(-16'sd32768, -16'sd32768, -16'sd32768);
        send_cmd(16'sd32767, -16'sd32768, 16'sd0);
        send_cmd(-16'sd1, -16'sd1, -16'sd1);
        drain();
    endtask

    task automatic test_register_width;
        write_reg(REG_LIMIT_VX, 16'h8BB8);
        write_reg(REG_LIMIT_VY, 16'hC3E8);
        write_reg(REG_LIMIT_VW, 16'h80C8);
        write_reg(REG_ROT_GAIN, 16'h0240);
        write_reg(REG_RPM_GAIN, 16'h8000);
        write_reg(REG_LIMIT_WHEEL_RPM, 16'hABCD);
        write_reg(REG_SPARE_LO, 16'h0000);
        write_reg(REG_SPARE_HI, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_cmd(16'sd4000, -16'sd2000, 16'sd500);
        send_cmd(-16'sd32768, 16'sd777, -16'sd250);
        send_cmd(16'sd32767, 16'sd32767, 16'sd32767);
        drain();
    endtask

    task automatic test_random_mix(int phase);
        set_config(rand_reg(4000), rand_reg(4000), rand_reg(720),
                   rand_reg(16'h0800), rand_reg(16'hFFFF), rand_reg(12000));
        send_idle = (phase == 2) ? 1'b0 : $urandom_range(0, 3) != 0;
        rx_idle  <= (phase == 2) ? 1'b0 : $urandom_range(0, 3) != 0;
        repeat (PHASE_WORDS)
            send_cmd(rand_speed(reg_limit_vx), rand_speed(reg_limit_vy),
                     rand_speed(reg_limit_vw));
        drain();
    endtask

    task automatic test_output_stall;
        set_config(16'd3000, 16'd3000, 16'd300, 16'h0300, 16'h4000, 16'd8000);
        send_idle = 1'b0;
        rx_idle  <= 1'b1;
        fork
            rx_hold(400);
        join_none
        repeat (60)
            send_cmd(rand_speed(reg_limit_vx), rand_speed(reg_limit_vy),
                     rand_speed(reg_limit_vw));
        drain();
    endtask

    task automatic test_sender_pause;
        send_idle = 1'b0;
        repeat (15)
            send_cmd(rand_speed(reg_limit_vx), rand_speed(reg_limit_vy),
                     rand_speed(reg_limit_vw));
        drain();
        repeat (15)
            send_cmd(rand_speed(reg_limit_vx), rand_speed(reg_limit_vy),
                     rand_speed(reg_limit_vw));
        drain();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_field_extremes();
        test_zero_speed_limits();
        test_zero_wheel_limit();
        test_saturation();
        test_register_width();
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
            test_random_mix(ph);
        test_output_stall();
        test_sender_pause();
        repeat (FLUSH_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_wheels.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
